FILE: src/assert_macros.svh
// assertion macros used by the life stream rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: src/lcng_pkg.sv
// types, constants and the b3/s23 rule for the life stream block
package lcng_pkg;

	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 11;
	localparam int GRID_WIDTH_W = 9;
	localparam int GRID_HEIGHT_W = 11;
	localparam int OUT_ROW_W    = 10;
	localparam int OUT_COL_W    = 8;

	localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RESET  = 9'd140;
	localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RESET = 11'd70;

	// smallest grid side in use
	localparam int MIN_SIDE = 3;

	// neighbour counts of the rule
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic cell_alive;
		logic flush;
	} cell_beat_t;

	typedef struct packed {
		logic                 next_alive;
		logic [OUT_ROW_W-1:0] out_row;
		logic [OUT_COL_W-1:0] out_column;
		logic                 last_of_frame;
	} result_beat_t;

	// window bit = 3*row + column, row 0 oldest
	// right_edge: center is column 2 and has no right neighbour
	// otherwise: center is column 1, left column counts when has_left
	function automatic logic life_next(logic [8:0] win, logic right_edge, logic has_left);
		logic [3:0] n;
		logic       center;
		if (right_edge) begin
			n = 4'(win[1]) + 4'(win[4]) + 4'(win[7]) + 4'(win[2]) + 4'(win[8]);
			center = win[5];
		end else begin
			n = 4'(win[2]) + 4'(win[5]) + 4'(win[8]) + 4'(win[1]) + 4'(win[7]);
			if (has_left) begin
				n = n + 4'(win[0]) + 4'(win[3]) + 4'(win[6]);
			end
			center = win[4];
		end
		return (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && center);
	endfunction

endpackage

FILE: src/lcng_ram.sv
// generic single-port-write ram with one registered read port
module lcng_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: src/life_cell_next_generation_stream.sv
// streaming b3/s23 life: next state of each raster cell from two buffered rows and a 3x3 window
// throughput one cell beat per clock; the input stalls only when the four-entry result queue
// cannot hold the beats in flight, which happens only while the output stalls
// a cell's result beat is written to the result queue in the cycle after the input beat one row plus
// one cell later is taken: stage 0 reads the row memory, stage 1 runs the rule and the queue write
// reset clears geometry to 140x70, position, window and the result queue; the row memory
// needs no clearing pass since rows not yet written in a frame are masked by the row count
`include "assert_macros.svh"

module life_cell_next_generation_stream #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lcng_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lcng_pkg::CFG_DATA_W-1:0]     cfg_data,
	// cell channel
	input  logic                                cell_valid,
	output logic                                cell_stall,
	input  lcng_pkg::cell_beat_t                cell_data,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output lcng_pkg::result_beat_t              result_data
);

	localparam int CW = $clog2(MAX_WIDTH);        // column index
	localparam int WW = $clog2(MAX_WIDTH + 1);    // width in use
	localparam int HW = $clog2(MAX_HEIGHT + 1);   // height in use
	localparam int RW = $clog2(MAX_HEIGHT + 2);   // input row, runs to height + 1
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [lcng_pkg::GRID_WIDTH_W-1:0]  grid_width_q;
	logic [lcng_pkg::GRID_HEIGHT_W-1:0] grid_height_q;
	logic                               cfg_wr;
	logic                               cfg_clear;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	// any write to a known register restarts the frame
	assign cfg_clear = cfg_wr && ((cfg_index == lcng_pkg::REG_GRID_WIDTH) ||
		(cfg_index == lcng_pkg::REG_GRID_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= lcng_pkg::GRID_WIDTH_RESET;
			grid_height_q <= lcng_pkg::GRID_HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				lcng_pkg::REG_GRID_WIDTH: begin
					grid_width_q <= cfg_data[lcng_pkg::GRID_WIDTH_W-1:0];
				end
				lcng_pkg::REG_GRID_HEIGHT: begin
					grid_height_q <= cfg_data[lcng_pkg::GRID_HEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// geometry in use, saturated to [3, max]
	logic [WW-1:0] used_w;
	logic [HW-1:0] used_h;

	always_comb begin
		if (32'(grid_width_q) > 32'(MAX_WIDTH)) begin
			used_w = WW'(MAX_WIDTH);
		end else if (32'(grid_width_q) < 32'(lcng_pkg::MIN_SIDE)) begin
			used_w = WW'(lcng_pkg::MIN_SIDE);
		end else begin
			used_w = WW'(grid_width_q);
		end
		if (32'(grid_height_q) > 32'(MAX_HEIGHT)) begin
			used_h = HW'(MAX_HEIGHT);
		end else if (32'(grid_height_q) < 32'(lcng_pkg::MIN_SIDE)) begin
			used_h = HW'(lcng_pkg::MIN_SIDE);
		end else begin
			used_h = HW'(grid_height_q);
		end
	end

	// ---------------------------------------------------------------
	// stage 0: raster position, row memory read
	// ---------------------------------------------------------------
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          cell_acc;
	logic          ignore;
	logic          take;
	logic          cell_v;
	logic          emit_c0;
	logic          emit_cn;
	logic          take_last;
	logic [WW-1:0] col_inc;
	logic [RW-1:0] row_next;
	logic [CW-1:0] col_next;
	logic [lcng_pkg::OUT_ROW_W-1:0] orow;
	logic [lcng_pkg::OUT_COL_W-1:0] ocol;

	assign cell_acc = cell_valid && !cell_stall;

	always_comb begin
		// padding at the very start of a frame is dropped without effect
		ignore = cell_data.flush && (row_q == '0) && (col_q == '0);
		take = cell_acc && !ignore;
		// padding and rows past the grid enter as dead cells
		cell_v = cell_data.cell_alive && !cell_data.flush && (row_q < RW'(used_h));
		// column 0 emits the last cell of the row two rows up
		emit_c0 = (row_q >= RW'(2)) && (col_q == '0);
		// other columns emit the cell one row up, one column left
		emit_cn = (row_q >= RW'(1)) && (col_q != '0);
		// last cell of the frame comes out at column 0 of row height + 1
		take_last = (row_q == (RW'(used_h) + RW'(1))) && (col_q == '0);

		if (emit_c0) begin
			orow = lcng_pkg::OUT_ROW_W'(row_q - RW'(2));
			ocol = lcng_pkg::OUT_COL_W'(used_w - WW'(1));
		end else begin
			orow = lcng_pkg::OUT_ROW_W'(row_q - RW'(1));
			ocol = lcng_pkg::OUT_COL_W'(col_q - CW'(1));
		end

		col_inc = WW'(col_q) + WW'(1);
		if (take_last) begin
			row_next = '0;
			col_next = '0;
		end else if (col_inc >= used_w) begin
			row_next = row_q + RW'(1);
			col_next = '0;
		end else begin
			row_next = row_q;
			col_next = CW'(col_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_clear) begin
			row_q <= '0;
			col_q <= '0;
		end else if (take) begin
			row_q <= row_next;
			col_q <= col_next;
		end
	end

	// row memory entry per column: bit 1 row r-2, bit 0 row r-1
	logic       mem_we;
	logic [1:0] mem_wdata;
	logic [1:0] mem_rdata;

	// ---------------------------------------------------------------
	// stage 1: window shift, rule, write back
	// ---------------------------------------------------------------
	logic                           valid_s1;
	logic                           alive_s1;
	logic [CW-1:0]                  col_s1;
	logic                           above_ok_s1;
	logic                           middle_ok_s1;
	logic                           left_s1;
	logic                           c0_s1;
	logic                           cn_s1;
	logic                           last_s1;
	logic [lcng_pkg::OUT_ROW_W-1:0] orow_s1;
	logic [lcng_pkg::OUT_COL_W-1:0] ocol_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			alive_s1     <= cell_v;
			col_s1       <= col_q;
			above_ok_s1  <= row_q >= RW'(2);
			middle_ok_s1 <= row_q >= RW'(1);
			left_s1      <= col_q >= CW'(2);
			c0_s1        <= emit_c0;
			cn_s1        <= emit_cn;
			last_s1      <= take_last;
			orow_s1      <= orow;
			ocol_s1      <= ocol;
		end
	end

	lcng_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_row_mem (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(col_s1),
		.wr_data(mem_wdata),
		.rd_en  (take),
		.rd_addr(col_q),
		.rd_data(mem_rdata)
	);

	logic [8:0] window_q;
	logic [8:0] win_next;
	logic       above_v;
	logic       middle_v;
	logic       push;
	lcng_pkg::result_beat_t push_beat;

	always_comb begin
		// rows not yet written in this frame read as dead
		above_v  = mem_rdata[1] && above_ok_s1;
		middle_v = mem_rdata[0] && middle_ok_s1;
		win_next = {alive_s1, window_q[8:7], middle_v, window_q[5:4], above_v, window_q[2:1]};

		mem_we    = valid_s1;
		mem_wdata = {middle_v, alive_s1};

		push = valid_s1 && (c0_s1 || cn_s1);
		push_beat.out_row       = orow_s1;
		push_beat.out_column    = ocol_s1;
		push_beat.last_of_frame = last_s1;
		if (c0_s1) begin
			// right edge cell of the previous row, from the window before the shift
			push_beat.next_alive = lcng_pkg::life_next(window_q, 1'b1, 1'b1);
		end else begin
			push_beat.next_alive = lcng_pkg::life_next(win_next, 1'b0, left_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (cfg_clear) begin
			window_q <= '0;
		end else if (valid_s1) begin
			// the frame's last cell leaves an empty window for the next frame
			window_q <= last_s1 ? '0 : win_next;
		end
	end

	// ---------------------------------------------------------------
	// result queue: absorbs the stage 1 beat while the output stalls
	// ---------------------------------------------------------------
	lcng_pkg::result_beat_t fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]     wr_ptr_q;
	logic [FIFO_AW-1:0]     rd_ptr_q;
	logic [FIFO_CW-1:0]     count_q;
	logic                   pop;

	assign result_valid = count_q != '0;
	assign result_data  = fifo_q[rd_ptr_q];
	assign pop = result_valid && !result_stall;
	// room for the beat in stage 1 and one more behind it
	assign cell_stall = (count_q + FIFO_CW'(valid_s1)) >= FIFO_CW'(FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + FIFO_CW'(push) - FIFO_CW'(pop);
		end
	end

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	// row 0 reads are masked, so a same-column access at a frame start is harmless
	`ASSERT_NEVER(a_queue_overflow, clk, arst_n, push && !pop && (count_q == FIFO_CW'(FIFO_DEPTH)))
	`ASSERT_NEVER(a_row_mem_collision, clk, arst_n, mem_we && take && (col_s1 == col_q) && (row_q != '0))
	`ASSERT_NEVER(a_column_range, clk, arst_n, WW'(col_q) >= used_w)
	`ASSERT_CLK(a_frame_restart, clk, arst_n, (take && take_last && !cfg_clear) |=> ((row_q == '0) && (col_q == '0)))

endmodule
